FILE: hw/rtl/psva_pkg.sv
package psva_pkg;

  localparam int CHAN_W      = 16;
  localparam int PCT_W       = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int LUMA_W      = 32;
  localparam int PSAT_W      = 17;
  localparam int NUM_W       = 26;
  localparam int GAIN_W      = 18;
  localparam int DELTA_W     = 33;
  localparam int PROD_W      = 36;
  localparam int TOTAL_W     = 54;
  localparam int DIV_STAGES  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIBRANCE   = 2'd1;

  localparam logic signed [PCT_W-1:0] PCT_MAX = 8'sd100;
  localparam logic signed [PCT_W-1:0] PCT_MIN = -8'sd100;

  localparam logic [CHAN_W-1:0] LUMA_WEIGHT_R = 16'd13933;
  localparam logic [CHAN_W-1:0] LUMA_WEIGHT_G = 16'd46871;
  localparam logic [CHAN_W-1:0] LUMA_WEIGHT_B = 16'd4732;

  localparam logic [PSAT_W-1:0]       PSAT_ONE    = 17'h10000;
  localparam logic signed [NUM_W-1:0] NUM_BASE    = 26'sd6553600;
  localparam logic [24:0]             NUM_ROUND   = 25'd50;
  localparam logic [25:0]             RECIP_100   = 26'd42949673;
  localparam int                      RECIP_SHIFT = 32;
  localparam logic [GAIN_W-1:0]       GAIN_MAX    = 18'd196608;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } pixel_out_t;

  typedef struct packed {
    logic delta_en;
    logic hold_en;
    logic prod_en;
  } lane_en_t;

endpackage

FILE: hw/rtl/psva_div.sv
module psva_div (
  input  logic                                clk,
  input  logic [psva_pkg::DIV_STAGES-1:0]     en,
  input  logic [psva_pkg::CHAN_W-1:0]         divisor,
  input  logic [psva_pkg::CHAN_W-1:0]         diff,
  output logic [psva_pkg::PSAT_W-1:0]         quotient
);
  import psva_pkg::*;

  logic [CHAN_W-1:0] rem [DIV_STAGES];
  logic [PSAT_W-1:0] q   [DIV_STAGES];
  logic [CHAN_W-1:0] dv  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [CHAN_W:0]   t;
    logic [CHAN_W:0]   sub;
    logic [CHAN_W-1:0] dv_in;
    logic [PSAT_W-1:0] q_in;
    logic              take;

    if (k == 0) begin : g_first
      assign t     = {1'b0, diff};
      assign dv_in = divisor;
      assign q_in  = '0;
    end else begin : g_next
      assign t     = {rem[k-1], 1'b0};
      assign dv_in = dv[k-1];
      assign q_in  = q[k-1];
    end

    assign take = t >= {1'b0, dv_in};
    assign sub  = t - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= take ? sub[CHAN_W-1:0] : t[CHAN_W-1:0];
        q[k]   <= {q_in[PSAT_W-2:0], take};
        dv[k]  <= dv_in;
      end
    end
  end

  assign quotient = (dv[DIV_STAGES-1] == '0) ? '0 : q[DIV_STAGES-1];

endmodule

FILE: hw/rtl/psva_lane.sv
module psva_lane (
  input  logic                           clk,
  input  psva_pkg::lane_en_t             en,
  input  logic [psva_pkg::CHAN_W-1:0]    chan,
  input  logic [psva_pkg::LUMA_W-1:0]    luma,
  input  logic [psva_pkg::GAIN_W-1:0]    gain,
  input  logic [psva_pkg::LUMA_W-1:0]    luma_late,
  output logic [psva_pkg::CHAN_W-1:0]    level
);
  import psva_pkg::*;

  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] delta_hold;
  logic signed [PROD_W-1:0]  pp_hi;
  logic signed [PROD_W-1:0]  pp_lo;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] rnd;

  always_ff @(posedge clk) begin
    if (en.delta_en) begin
      delta <= $signed({1'b0, chan, 16'd0}) - $signed({1'b0, luma});
    end
    if (en.hold_en) begin
      delta_hold <= delta;
    end
    if (en.prod_en) begin
      pp_hi <= $signed(delta_hold[DELTA_W-1:16]) * $signed({1'b0, gain});
      pp_lo <= $signed({1'b0, delta_hold[15:0]}) * $signed({1'b0, gain});
    end
  end

  always_comb begin
    total = $signed({6'd0, luma_late, 16'd0})
          + $signed({{2{pp_hi[PROD_W-1]}}, pp_hi, 16'd0})
          + $signed({{(TOTAL_W-PROD_W){pp_lo[PROD_W-1]}}, pp_lo});
    rnd = total + 54'sh0000_8000_0000;
    if (total[TOTAL_W-1] || total == '0) begin
      level = '0;
    end else if (|rnd[TOTAL_W-1:48]) begin
      level = '1;
    end else begin
      level = rnd[47:32];
    end
  end

endmodule

FILE: hw/rtl/pixel_saturation_vibrance_adjust.sv
// Saturation and vibrance adjustment for 16-bit RGB pixels. One pixel request is taken
// every clock; each passes an input register, the 17-stage restoring divider that forms the
// pixel saturation (max-min)/max, and then the numerator, gain, product and output registers;
// stalls on the result side hold the pipeline, and empty stages still fill while the result
// waits. Three channel lanes apply luma + (channel - luma) * gain in parallel and the final
// register merges them with the bypass path used when both amounts are zero. Amounts are
// whole percents, clamped to -100..100 on write; write them only while no request is in flight.
module pixel_saturation_vibrance_adjust (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  psva_pkg::pixel_in_t                  pixel,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output psva_pkg::pixel_out_t                 result,
  input  logic                                 cfg_we,
  input  logic [psva_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [psva_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psva_pkg::*;

  localparam int ST_DIV  = 1;
  localparam int ST_NUM  = ST_DIV + DIV_STAGES;
  localparam int ST_GAIN = ST_NUM + 1;
  localparam int ST_PROD = ST_GAIN + 1;
  localparam int ST_OUT  = ST_PROD + 1;
  localparam int STAGES  = ST_OUT + 1;

  logic signed [PCT_W-1:0] sat_pct;
  logic signed [PCT_W-1:0] vib_pct;
  logic signed [PCT_W-1:0] cfg_pct;

  always_comb begin
    cfg_pct = $signed(cfg_data);
    if (cfg_pct > PCT_MAX) begin
      cfg_pct = PCT_MAX;
    end else if (cfg_pct < PCT_MIN) begin
      cfg_pct = PCT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_pct <= '0;
      vib_pct <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SATURATION: sat_pct <= cfg_pct;
        CFG_VIBRANCE:   vib_pct <= cfg_pct;
        default: ;
      endcase
    end
  end

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en[k] = result_ready || !(&vld[STAGES-1:k]);
  end

  assign pixel_ready  = en[0];
  assign result_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;

  always_comb begin
    mx = pixel.red_in;
    mn = pixel.red_in;
    if (pixel.green_in > mx) mx = pixel.green_in;
    if (pixel.blue_in > mx) mx = pixel.blue_in;
    if (pixel.green_in < mn) mn = pixel.green_in;
    if (pixel.blue_in < mn) mn = pixel.blue_in;
  end

  pixel_in_t         pix_pipe  [ST_OUT];
  logic [ST_OUT-1:0] byp_pipe;
  logic [LUMA_W-1:0] luma_pipe [ST_DIV:ST_PROD];
  logic [CHAN_W-1:0] mx0;
  logic [CHAN_W-1:0] diff0;
  logic [LUMA_W-1:0] pr;
  logic [LUMA_W-1:0] pg;
  logic [LUMA_W-1:0] pb;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix_pipe[0] <= pixel;
      byp_pipe[0] <= (sat_pct == '0) && (vib_pct == '0);
      mx0         <= mx;
      diff0       <= mx - mn;
      pr          <= {16'd0, LUMA_WEIGHT_R} * {16'd0, pixel.red_in};
      pg          <= {16'd0, LUMA_WEIGHT_G} * {16'd0, pixel.green_in};
      pb          <= {16'd0, LUMA_WEIGHT_B} * {16'd0, pixel.blue_in};
    end
    if (en[ST_DIV]) begin
      luma_pipe[ST_DIV] <= pr + pg + pb;
    end
    for (int k = ST_DIV + 1; k <= ST_PROD; k++) begin
      if (en[k]) begin
        luma_pipe[k] <= luma_pipe[k-1];
      end
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        pix_pipe[k] <= pix_pipe[k-1];
        byp_pipe[k] <= byp_pipe[k-1];
      end
    end
  end

  logic [PSAT_W-1:0] psat;

  psva_div u_div (
    .clk      (clk),
    .en       (en[ST_NUM-1:ST_DIV]),
    .divisor  (mx0),
    .diff     (diff0),
    .quotient (psat)
  );

  logic [PSAT_W-1:0]        one_minus;
  logic signed [NUM_W-1:0]  sat_term;
  logic signed [NUM_W-1:0]  vib_term;
  logic signed [NUM_W-1:0]  num;
  logic [24:0]              num_rnd;
  logic [50:0]              gain_prod;
  logic [GAIN_W-1:0]        gain;

  assign one_minus = PSAT_ONE - psat;
  assign sat_term  = $signed({{(NUM_W-PCT_W-16){sat_pct[PCT_W-1]}}, sat_pct, 16'd0});
  assign vib_term  = vib_pct * $signed({1'b0, one_minus});
  assign num_rnd   = num[24:0] + NUM_ROUND;
  assign gain_prod = {26'd0, num_rnd} * {25'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      num <= NUM_BASE + sat_term + vib_term;
    end
    if (en[ST_GAIN]) begin
      gain <= (!num[NUM_W-1] && num != '0)
            ? gain_prod[RECIP_SHIFT+GAIN_W-1:RECIP_SHIFT] : '0;
    end
  end

  lane_en_t          lane_en;
  logic [CHAN_W-1:0] red_level;
  logic [CHAN_W-1:0] green_level;
  logic [CHAN_W-1:0] blue_level;

  assign lane_en = '{delta_en: en[ST_NUM], hold_en: en[ST_GAIN], prod_en: en[ST_PROD]};

  psva_lane u_lane_red (
    .clk       (clk),
    .en        (lane_en),
    .chan      (pix_pipe[ST_NUM-1].red_in),
    .luma      (luma_pipe[ST_NUM-1]),
    .gain      (gain),
    .luma_late (luma_pipe[ST_PROD]),
    .level     (red_level)
  );

  psva_lane u_lane_green (
    .clk       (clk),
    .en        (lane_en),
    .chan      (pix_pipe[ST_NUM-1].green_in),
    .luma      (luma_pipe[ST_NUM-1]),
    .gain      (gain),
    .luma_late (luma_pipe[ST_PROD]),
    .level     (green_level)
  );

  psva_lane u_lane_blue (
    .clk       (clk),
    .en        (lane_en),
    .chan      (pix_pipe[ST_NUM-1].blue_in),
    .luma      (luma_pipe[ST_NUM-1]),
    .gain      (gain),
    .luma_late (luma_pipe[ST_PROD]),
    .level     (blue_level)
  );

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (byp_pipe[ST_OUT-1]) begin
        result.red_out   <= pix_pipe[ST_OUT-1].red_in;
        result.green_out <= pix_pipe[ST_OUT-1].green_in;
        result.blue_out  <= pix_pipe[ST_OUT-1].blue_in;
      end else begin
        result.red_out   <= red_level;
        result.green_out <= green_level;
        result.blue_out  <= blue_level;
      end
    end
  end

`ifndef ASSERT_OFF
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !result_ready) |-> !pixel_ready)
    else $error("request taken while pipeline full and stalled");

  a_request_enters: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready) |=> vld[0])
    else $error("accepted request lost at pipeline entry");

  a_psat_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_NUM-1] |-> (psat <= PSAT_ONE))
    else $error("pixel saturation above one");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    vld[ST_GAIN] |-> (gain <= GAIN_MAX))
    else $error("gain above three");
`endif

endmodule
